// File: sv/ntim_pkg.sv
// package for the note target interval matcher
// holds widths, command/action/policy/register codes and the log2 of 440 constant; no dependencies
package ntim_pkg;

    localparam int TimeW   = 52;
    localparam int PitchW  = 16;
    localparam int DefMaxTargets = 64;

    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdLoad  = 2'd1;
    localparam logic [1:0] CmdNote  = 2'd2;

    localparam logic [1:0] ActLeave  = 2'd0;
    localparam logic [1:0] ActShift  = 2'd1;
    localparam logic [1:0] ActMute   = 2'd2;

    localparam logic [1:0] PolLeave   = 2'd0;
    localparam logic [1:0] PolMute    = 2'd1;
    localparam logic [1:0] PolNearest = 2'd2;

    localparam logic [1:0] RegRate   = 2'd0;
    localparam logic [1:0] RegRatio  = 2'd1;
    localparam logic [1:0] RegMaxCor = 2'd2;
    localparam logic [1:0] RegPolicy = 2'd3;

    localparam logic signed [40:0] Log2Of440 = 41'sd575495;

endpackage

// File: sv/ntim_log2.sv
// iterative log2 of a 32 bit value into Q5.16, one squaring per cycle
// depends on ntim_pkg
module ntim_log2 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [20:0] o_log
);
    import ntim_pkg::*;

    logic [32:0] r_m, n_m;
    logic [4:0]  r_msb, n_msb;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [65:0] w_sq;
    logic [34:0] w_sh;

    assign w_sq = r_m * r_m;
    assign w_sh = w_sq[65:31];

    always_comb begin
        n_m = r_m;
        n_msb = r_msb;
        n_frac = r_frac;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_msb = 5'd0;
            for (int k = 0; k < 32; k++) begin
                if (i_value[k]) n_msb = 5'(k);
            end
            n_m = {1'b0, i_value << (5'd31 - n_msb)};
            n_frac = '0;
            n_cnt = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh[32]) begin
                n_m = w_sh[33:1];
                n_frac = {r_frac[14:0], 1'b1};
            end else begin
                n_m = w_sh[32:0];
                n_frac = {r_frac[14:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_m <= n_m;
        r_msb <= n_msb;
        r_frac <= n_frac;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_log = {r_msb, r_frac};
endmodule

// File: sv/ntim_table.sv
// target table memory: start, end and pitch, one write and one read port
// depends on ntim_pkg
module ntim_table #(
    parameter int MaxTargets = ntim_pkg::DefMaxTargets,
    parameter int IdxW = $clog2(MaxTargets) > 0 ? $clog2(MaxTargets) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [IdxW-1:0]          i_waddr,
    input  logic [ntim_pkg::TimeW-1:0] i_wstart,
    input  logic [ntim_pkg::TimeW-1:0] i_wend,
    input  logic [ntim_pkg::PitchW-1:0] i_wpitch,
    input  logic [IdxW-1:0]          i_raddr,
    output logic [ntim_pkg::TimeW-1:0] o_rstart,
    output logic [ntim_pkg::TimeW-1:0] o_rend,
    output logic [ntim_pkg::PitchW-1:0] o_rpitch
);
    import ntim_pkg::*;

    logic [2*TimeW+PitchW-1:0] r_mem [MaxTargets];
    logic [2*TimeW+PitchW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= {i_wpitch, i_wend, i_wstart};
        r_q <= r_mem[i_raddr];
    end

    assign o_rstart = r_q[TimeW-1:0];
    assign o_rend   = r_q[2*TimeW-1:TimeW];
    assign o_rpitch = r_q[2*TimeW+PitchW-1:2*TimeW];
endmodule

// File: sv/note_target_interval_matcher.sv
// Note target interval matcher. Commands clear the table, load a
// target (a 32x20 multiply per bound), or process a note. A note scans
// the target table through a one-read-port memory, one entry per cycle,
// once for the overlap search and, when nothing matched and the nearest
// policy is set, once more for the gap search; then, when a target was
// found, a 16-step iterative log2 runs. One word is handled at a time; the
// result sits in an output register, and the next word is taken once the
// result has been accepted. Table contents are undefined until loaded.
// Depends on ntim_pkg, ntim_table and ntim_log2.
module note_target_interval_matcher #(
    parameter int MaxTargets = ntim_pkg::DefMaxTargets,
    parameter int IdxW = $clog2(MaxTargets) > 0 ? $clog2(MaxTargets) : 1,
    parameter int CntW = $clog2(MaxTargets + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // target_start[31:0], target_end[63:32], target_pitch[79:64],
    // note_onset[111:80], note_offset[143:112], note_freq[175:144]
    input  logic [175:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pitch_shift[15:0], assigned_count[47:16]
    output logic [47:0]  m_axis_tdata,
    // action[1:0]
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ntim_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_NEAR  = 7'b0001000,
        S_LOG   = 7'b0010000,
        S_SHIFT = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [19:0] r_rate;
    logic [16:0] r_ratio;
    logic [14:0] r_maxcor;
    logic [1:0]  r_policy;

    logic [CntW-1:0] r_count;
    logic [31:0]     r_total;

    logic [1:0]  w_cmd;
    assign w_cmd = s_axis_tuser;

    logic [31:0] r_a0, r_a1, r_onset, r_offset, r_freq;
    logic [15:0] r_pitch_in;
    logic [TimeW-1:0] r_ld_start;
    logic [1:0]  r_ld_step;

    logic [CntW:0]   r_idx;
    logic            r_rvalid;
    logic [IdxW-1:0] r_ridx;
    logic            r_found;
    logic [TimeW:0]  r_best_val;
    logic [TimeW-1:0] r_best_start;
    logic [15:0]     r_best_pitch;
    logic [48:0]     r_required;
    logic            r_log_start;

    logic [1:0]  r_act;
    logic signed [15:0] r_shift;

    logic [TimeW-1:0] w_rstart, w_rend;
    logic [15:0]      w_rpitch;
    logic             w_done;
    logic [20:0]      w_log;

    logic             w_we;
    logic [TimeW-1:0] w_prod;
    assign w_prod = TimeW'(r_a0 * r_rate);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_we = (r_state == S_LOAD) && (r_ld_step == 2'd1);

    ntim_table #(.MaxTargets(MaxTargets), .IdxW(IdxW)) u_table (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(IdxW'(r_count)),
        .i_wstart(r_ld_start), .i_wend(w_prod), .i_wpitch(r_pitch_in),
        .i_raddr(IdxW'(r_idx)),
        .o_rstart(w_rstart), .o_rend(w_rend), .o_rpitch(w_rpitch)
    );

    ntim_log2 u_log (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_log_start),
        .i_value(r_freq), .o_done(w_done), .o_log(w_log)
    );

    // overlap and gap of the entry read last cycle, signed 54 bit
    logic signed [TimeW+1:0] w_ns, w_ne, w_ts, w_te, w_lo, w_hi, w_ov, w_g1, w_g2, w_gap;
    always_comb begin
        w_ns = {6'd0, r_onset, 16'd0};
        w_ne = {6'd0, r_offset, 16'd0};
        w_ts = {2'b0, w_rstart};
        w_te = {2'b0, w_rend};
        w_hi = (w_ne < w_te) ? w_ne : w_te;
        w_lo = (w_ns > w_ts) ? w_ns : w_ts;
        w_ov = w_hi - w_lo;
        w_g1 = w_ts - w_ne;
        w_g2 = w_ns - w_te;
        w_gap = (w_g1 > w_g2) ? w_g1 : w_g2;
        if (w_gap < 0) w_gap = '0;
    end

    logic w_ov_ok, w_ov_better, w_gap_better;
    always_comb begin
        w_ov_ok = (w_ov > 0) && (w_ov >= $signed({5'd0, r_required}));
        w_ov_better = !r_found || (w_ov[TimeW:0] > r_best_val) ||
                      ((w_ov[TimeW:0] == r_best_val) && (w_rstart < r_best_start));
        w_gap_better = !r_found || (w_gap[TimeW:0] < r_best_val) ||
                       ((w_gap[TimeW:0] == r_best_val) && (w_rstart < r_best_start));
    end

    // midi from log: 69*65536 + 12*(L - 16*65536 - log2 440)
    logic signed [40:0] w_midi16, w_l;
    logic signed [32:0] w_midi8;
    logic signed [33:0] w_s;
    logic signed [33:0] w_lim;
    always_comb begin
        w_l = $signed({20'd0, w_log});
        w_midi16 = 41'sd4521984 + 41'sd12 * (w_l - 41'sd1048576 - Log2Of440);
        w_midi8 = 33'((w_midi16 + 41'sd128) >>> 8);
        w_s = 34'($signed(r_best_pitch)) - 34'(w_midi8);
        w_lim = $signed({19'd0, r_maxcor});
        if (w_s > w_lim) w_s = w_lim;
        if (w_s < -w_lim) w_s = -w_lim;
    end

    logic [16:0] w_ratio_c;
    assign w_ratio_c = (r_ratio > 17'd65536) ? 17'd65536 : r_ratio;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (w_cmd == CmdLoad && r_count < CntW'(MaxTargets)) n_state = S_LOAD;
                    else if (w_cmd == CmdNote && r_rate != '0 &&
                             s_axis_tdata[175:144] != '0) n_state = S_SCAN;
                    else n_state = S_OUT;
                end
            end
            S_LOAD:  if (r_ld_step == 2'd1) n_state = S_OUT;
            S_SCAN: begin
                if (r_idx >= (CntW+1)'(r_count) && !r_rvalid) begin
                    if (r_found) n_state = S_LOG;
                    else if (r_policy == PolNearest && r_count != '0) n_state = S_NEAR;
                    else n_state = S_OUT;
                end
            end
            S_NEAR: if (r_idx >= (CntW+1)'(r_count) && !r_rvalid) n_state = S_LOG;
            S_LOG:   if (w_done) n_state = S_SHIFT;
            S_SHIFT: n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate <= 20'd48000;
            r_ratio <= '0;
            r_maxcor <= 15'd512;
            r_policy <= PolLeave;
            r_count <= '0;
            r_total <= '0;
            r_log_start <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_log_start <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegRate:   r_rate <= i_cfg_data[19:0];
                    RegRatio:  r_ratio <= i_cfg_data[16:0];
                    RegMaxCor: r_maxcor <= i_cfg_data[14:0];
                    RegPolicy: r_policy <= i_cfg_data[1:0];
                    default:   r_rate <= r_rate;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_act <= ActLeave;
                    r_shift <= '0;
                    r_found <= 1'b0;
                    r_idx <= '0;
                    r_rvalid <= 1'b0;
                    r_ld_step <= '0;
                    r_a0 <= s_axis_tdata[31:0];
                    r_a1 <= s_axis_tdata[63:32];
                    r_pitch_in <= s_axis_tdata[79:64];
                    r_onset <= s_axis_tdata[111:80];
                    r_offset <= s_axis_tdata[143:112];
                    r_freq <= s_axis_tdata[175:144];
                    r_required <= 49'(w_ratio_c * (s_axis_tdata[143:112] - s_axis_tdata[111:80]));
                    if (s_axis_tvalid && w_cmd == CmdClear) begin
                        r_count <= '0;
                        r_total <= '0;
                    end
                    // no overlap search for an empty or reversed note
                    if (s_axis_tdata[143:112] <= s_axis_tdata[111:80]) r_idx <= (CntW+1)'(MaxTargets);
                end
                S_LOAD: begin
                    r_ld_step <= r_ld_step + 2'd1;
                    if (r_ld_step == 2'd0) begin
                        r_ld_start <= w_prod;
                        r_a0 <= r_a1;
                    end else begin
                        r_count <= r_count + CntW'(1);
                    end
                end
                S_SCAN, S_NEAR: begin
                    r_rvalid <= (r_idx < (CntW+1)'(r_count));
                    r_ridx <= IdxW'(r_idx);
                    if (r_idx < (CntW+1)'(r_count)) r_idx <= r_idx + 1'b1;
                    if (r_rvalid) begin
                        if (r_state == S_SCAN ? (w_ov_ok && w_ov_better) : w_gap_better) begin
                            r_found <= 1'b1;
                            r_best_val <= (r_state == S_SCAN) ? w_ov[TimeW:0] : w_gap[TimeW:0];
                            r_best_start <= w_rstart;
                            r_best_pitch <= w_rpitch;
                        end
                    end
                    if (n_state == S_NEAR && r_state == S_SCAN) r_idx <= '0;
                    if (n_state == S_LOG) r_log_start <= 1'b1;
                    if (n_state == S_OUT && r_policy == PolMute) r_act <= ActMute;
                end
                S_SHIFT: begin
                    r_act <= ActShift;
                    r_shift <= w_s[15:0];
                    if (r_total != 32'hFFFF_FFFF) r_total <= r_total + 32'd1;
                end
                default: r_act <= r_act;
            endcase
        end
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {r_total, r_shift};
    assign m_axis_tuser = r_act;
endmodule

// File: tb/sv/testbench.sv
// self-checking bench for the note target interval matcher: drives command words,
// predicts each result word in a behavioral model and compares field by field
// depends on ntim_pkg and note_target_interval_matcher
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ntim_pkg::*;

    localparam int NumTargets = 64;
    localparam longint CycleLimit = 3000000;

    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] offset;
        logic [31:0] onset;
        logic [15:0] pitch;
        logic [31:0] tend;
        logic [31:0] tstart;
        logic [1:0]  cmd;
    } cmd_word_t;

    typedef struct packed {
        logic [31:0] count;
        logic [15:0] shift;
        logic [1:0]  action;
    } res_word_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    note_target_interval_matcher DUT (.*);

    // predictor state
    logic [51:0] tab_start [NumTargets];
    logic [51:0] tab_end [NumTargets];
    logic [15:0] tab_pitch [NumTargets];
    int unsigned tab_used;
    logic [31:0] note_total;
    logic [19:0] rate_reg;
    logic [16:0] ratio_reg;
    logic [14:0] maxcor_reg;
    logic [1:0]  policy_reg;

    cmd_word_t pending_words[$];
    res_word_t expected_results[$];
    int        fail_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    bit        hold_off;
    longint    cycle_count;

    function automatic longint log2_q16(logic [31:0] v);
        int msb;
        logic [63:0] m;
        logic [15:0] frac;
        msb = 31;
        frac = 0;
        while (msb > 0 && v[msb] == 1'b0) msb--;
        m = 64'(v) << (31 - msb);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (longint'(msb) << 16) + longint'(frac);
    endfunction

    function automatic logic [15:0] semitone_shift(logic [31:0] freq, logic [15:0] pitch);
        longint midi_q16;
        longint midi_q8;
        longint s;
        longint lim;
        midi_q16 = 69 * 65536 + 12 * (log2_q16(freq) - 16 * 65536 - 575495);
        midi_q8 = midi_q16 + 128;
        midi_q8 = (midi_q8 >= 0) ? midi_q8 / 256 : -((-midi_q8 + 255) / 256);
        s = longint'($signed(pitch)) - midi_q8;
        lim = longint'(maxcor_reg);
        if (s > lim) s = lim;
        if (s < -lim) s = -lim;
        return s[15:0];
    endfunction

    function automatic res_word_t match_note(cmd_word_t w);
        res_word_t r;
        longint ns, ne, ts, te, ov, g, required, best_val;
        bit found;
        int best;
        r = '0;
        case (w.cmd)
            CmdClear: begin
                tab_used = 0;
                note_total = 0;
            end
            CmdLoad: begin
                if (tab_used < NumTargets) begin
                    tab_start[tab_used] = 52'(w.tstart) * 52'(rate_reg);
                    tab_end[tab_used] = 52'(w.tend) * 52'(rate_reg);
                    tab_pitch[tab_used] = w.pitch;
                    tab_used++;
                end
            end
            CmdNote: begin
                if (rate_reg != 0 && w.freq != 0) begin
                    ns = longint'(w.onset) << 16;
                    ne = longint'(w.offset) << 16;
                    found = 0;
                    best = 0;
                    best_val = 0;
                    if (w.offset > w.onset) begin
                        required = (ratio_reg > 65536 ? 65536 : longint'(ratio_reg))
                                   * longint'(w.offset - w.onset);
                        for (int i = 0; i < tab_used; i++) begin
                            ts = longint'(tab_start[i]);
                            te = longint'(tab_end[i]);
                            ov = (ne < te ? ne : te) - (ns > ts ? ns : ts);
                            if (ov <= 0 || ov < required) continue;
                            if (!found || ov > best_val ||
                                (ov == best_val && tab_start[i] < tab_start[best])) begin
                                found = 1;
                                best = i;
                                best_val = ov;
                            end
                        end
                    end
                    if (!found && policy_reg == PolNearest) begin
                        for (int i = 0; i < tab_used; i++) begin
                            ts = longint'(tab_start[i]);
                            te = longint'(tab_end[i]);
                            g = (ts - ne > ns - te) ? ts - ne : ns - te;
                            if (g < 0) g = 0;
                            if (!found || g < best_val ||
                                (g == best_val && tab_start[i] < tab_start[best])) begin
                                found = 1;
                                best = i;
                                best_val = g;
                            end
                        end
                    end
                    if (found) begin
                        r.action = ActShift;
                        r.shift = semitone_shift(w.freq, tab_pitch[best]);
                        if (note_total != 32'hFFFF_FFFF) note_total++;
                    end else if (policy_reg == PolMute) begin
                        r.action = ActMute;
                    end
                end
            end
            default: ;
        endcase
        r.count = note_total;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // driver: offers queued words, predicts on acceptance
    always @(posedge i_clk) begin
        cmd_word_t head;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) expected_results.push_back(match_note(pending_words.pop_front()));
            if (s_axis_tvalid && !s_axis_tready) begin
                // keep offering the same word
            end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                head = pending_words[0];
                s_axis_tvalid <= 1;
                s_axis_tdata <= head[177:2];
                s_axis_tuser <= head.cmd;
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // monitor: compares each result word with the oldest prediction
    always @(posedge i_clk) begin
        res_word_t got, exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata, m_axis_tuser};
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", got);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.action !== exp_r.action) begin
                        $error("action expected %0d actual %0d", exp_r.action, got.action);
                        fail_count++;
                    end
                    if (got.shift !== exp_r.shift) begin
                        $error("pitch_shift expected %h actual %h", exp_r.shift, got.shift);
                        fail_count++;
                    end
                    if (got.count !== exp_r.count) begin
                        $error("assigned_count expected %0d actual %0d",
                               exp_r.count, got.count);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            RegRate:   rate_reg = val[19:0];
            RegRatio:  ratio_reg = val[16:0];
            RegMaxCor: maxcor_reg = val[14:0];
            default:   policy_reg = val[1:0];
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic cmd_word_t rand_word();
        cmd_word_t w;
        w = 178'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return w;
    endfunction

    // load word with a target in seconds, turned into samples by the rate
    task automatic push_load(logic [31:0] s_sec, logic [31:0] e_sec, logic [15:0] p);
        cmd_word_t w;
        w = rand_word();
        w.cmd = CmdLoad;
        w.tstart = s_sec;
        w.tend = e_sec;
        w.pitch = p;
        pending_words.push_back(w);
    endtask

    task automatic push_note(logic [31:0] on, logic [31:0] off, logic [31:0] f);
        cmd_word_t w;
        w = rand_word();
        w.cmd = CmdNote;
        w.onset = on;
        w.offset = off;
        w.freq = f;
        pending_words.push_back(w);
    endtask

    task automatic push_cmd(logic [1:0] c);
        cmd_word_t w;
        w = rand_word();
        w.cmd = c;
        pending_words.push_back(w);
    endtask

    // maybe a clear, targets on a short timeline, then mostly notes around them
    task automatic random_scene(int loads, int notes);
        int unsigned base;
        int unsigned on;
        base = $urandom_range(20);
        if ($urandom_range(3) == 0) push_cmd(CmdClear);
        for (int i = 0; i < loads; i++)
            push_load((base + $urandom_range(8)) << 16 | $urandom_range(65535),
                      (base + $urandom_range(10)) << 16 | $urandom_range(65535),
                      $urandom_range(99) < 80 ? 16'($urandom_range(20000, 30000))
                                              : 16'($urandom));
        for (int i = 0; i < notes; i++) begin
            on = (base + $urandom_range(10)) * rate_reg + $urandom_range(50000);
            case ($urandom_range(9))
                0: push_note($urandom, $urandom, $urandom);
                1: push_note(on, on + $urandom_range(200000), 0);
                2: push_cmd(2'd3);
                default: push_note(on, on + $urandom_range(1, 200000),
                                   $urandom_range(99) < 80 ? $urandom_range(20 << 16, 4000 << 16)
                                                           : $urandom);
            endcase
        end
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = CmdClear;
        m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = RegRate;
        i_cfg_data = 0;
        fail_count = 0;
        cycle_count = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tab_used = 0;
        note_total = 0;
        rate_reg = 48000;
        ratio_reg = 0;
        maxcor_reg = 512;
        policy_reg = PolLeave;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, every command and special case
        push_note(100, 200, 440 << 16);
        push_load(32'd1 << 16, 32'd2 << 16, 16'sd17664);
        push_load(32'd1 << 16, 32'd3 << 16, 16'sd15000);
        push_load(32'd5 << 16, 32'd4 << 16, 16'h8000);
        push_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF);
        push_note(48000, 96000, 440 << 16);
        push_note(48000, 144000, 32'd1);
        push_note(48000, 144000, 32'hFFFF_FFFF);
        push_note(96000, 48000, 440 << 16);
        push_note(0, 32'hFFFF_FFFF, 1000 << 16);
        push_note(10, 20, 0);
        push_note(300000, 400000, 300 << 16);
        push_cmd(2'd3);
        push_cmd(CmdClear);
        push_note(48000, 96000, 440 << 16);
        drain();
        write_reg(RegPolicy, PolNearest);
        write_reg(RegMaxCor, 32'h7FFF);
        write_reg(RegRatio, 32'h1FFFF);
        push_note(48000, 96000, 440 << 16);
        push_load(32'd1 << 16, 32'd2 << 16, 16'sd30000);
        push_load(32'd8 << 16, 32'd9 << 16, 16'sd100);
        push_note(48000, 96000, 220 << 16);
        push_note(300000, 350000, 880 << 16);
        for (int i = 0; i < 70; i++) push_load(i << 16, (i + 1) << 16, 16'($urandom));
        push_note(48000, 96000, 440 << 16);
        drain();
        write_reg(RegRate, 0);
        push_load(32'd1 << 16, 32'd2 << 16, 16'sd1);
        push_note(48000, 96000, 440 << 16);
        drain();

        for (int ph = 0; ph < 16; ph++) begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 38 : 61) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 38 : 61) : 0;
            write_reg(RegRate, ph == 5 ? 32'hFFFFF : (ph == 9 ? 0 : $urandom_range(8000, 96000)));
            write_reg(RegRatio, ph % 3 == 0 ? 0 : $urandom_range(70000));
            write_reg(RegMaxCor, ph == 7 ? 0 : $urandom_range(32767));
            write_reg(RegPolicy, ph % 4);
            push_cmd(CmdClear);
            for (int k = 0; k < 6; k++) random_scene($urandom_range(1, 12), $urandom_range(4, 14));
            if (ph == 4) begin
                hold_off = 1;
                repeat (2000) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end

        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
